FILE: src/sdrs_pkg.sv
// ----------------------------------------------------------------------------
// sdrs_pkg
// shared codes, widths and types of the sweep disk request scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package sdrs_pkg;

  localparam int TYPE_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int TIME_W     = 26;
  localparam int PEND_W     = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_REG_W  = 16;
  localparam int CFG_ADDR_W = 3;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam int                PEND_MAX = 31;

  // item codes
  localparam logic FN_ADD   = 1'b0;
  localparam logic FN_SERVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SERVED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  // register index, taken from paddr[2]
  localparam logic CFG_IDX_MOVE = 1'b0;
  localparam logic CFG_IDX_OP   = 1'b1;

  localparam logic [CFG_REG_W-1:0] MOVE_RST = 16'd1;
  localparam logic [CFG_REG_W-1:0] OP_RST   = 16'd0;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic add;
    logic srv;
    logic sweep;
  } sdrs_cmd_t;

endpackage

`default_nettype wire

FILE: src/sweep_disk_request_scheduler.sv
// ----------------------------------------------------------------------------
// sweep_disk_request_scheduler
// circular-scan disk request queue built as a sorted row of shift cells
// ----------------------------------------------------------------------------
// a result strobes on out_valid once the beat taken on start has passed stage 1 and stage 2
// throughput: one item per cycle; the cell row settles an add or serve as stage 1
//   registers the beat, and the service time multiply sits in the second stage
// busy stays low; the receiver cannot stall results
// reset: queue emptied, head at track 0, registers back to their defaults
// ----------------------------------------------------------------------------
`default_nettype none

module sweep_disk_request_scheduler #(
  parameter int QUEUE_DEPTH     = 16,
  parameter int TRACK_COUNT     = 1024,
  parameter int PROCESS_ID_BITS = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 in_func,
  input  wire logic [$clog2(TRACK_COUNT)-1:0]       in_track,
  input  wire logic [sdrs_pkg::TYPE_W-1:0]          in_op_type,
  input  wire logic [PROCESS_ID_BITS-1:0]           in_process_id,
  output logic                                      out_valid,
  output logic [sdrs_pkg::STATUS_W-1:0]             out_status,
  output logic [$clog2(TRACK_COUNT)-1:0]            out_served_track,
  output logic [sdrs_pkg::TYPE_W-1:0]               out_served_type,
  output logic [PROCESS_ID_BITS-1:0]                out_served_process,
  output logic [sdrs_pkg::TIME_W-1:0]               out_service_time,
  output logic                                      out_new_sweep,
  output logic [sdrs_pkg::PEND_W-1:0]               out_pending,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [sdrs_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [sdrs_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [sdrs_pkg::CFG_DATA_W-1:0]           prdata,
  output logic                                      pready
);

  import sdrs_pkg::*;

  localparam int TRK_W  = $clog2(TRACK_COUNT);
  localparam int PID_W  = PROCESS_ID_BITS;
  localparam int QD     = QUEUE_DEPTH;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int PROD_W = TRK_W + CFG_REG_W;
  localparam int SUM_W  = (PROD_W + 1 > TIME_W + 1) ? PROD_W + 1 : TIME_W + 1;
  localparam logic [TRK_W-1:0] TRK_MAX = TRK_W'(TRACK_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // configuration
  logic [CFG_REG_W-1:0] move_r, op_r;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_r <= MOVE_RST;
      op_r   <= OP_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        CFG_IDX_MOVE: move_r <= pwdata[CFG_REG_W-1:0];
        CFG_IDX_OP:   op_r   <= pwdata[CFG_REG_W-1:0];
        default:      move_r <= move_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_IDX_MOVE: prdata = {{(CFG_DATA_W-CFG_REG_W){1'b0}}, move_r};
      CFG_IDX_OP:   prdata = {{(CFG_DATA_W-CFG_REG_W){1'b0}}, op_r};
      default:      prdata = '0;
    endcase
  end

  // cell row
  logic                  acc;
  logic                  full, empty;
  sdrs_cmd_t             cmd;
  logic [TRK_W-1:0]      new_trk;
  logic [TRK_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  logic [QD-1:0]         vld_a, ins_a, rm_a, ge_a, hit_a;
  logic [TRK_W-1:0]      trk_a [QD];
  logic [TYPE_W-1:0]     typ_a [QD];
  logic [PID_W-1:0]      pid_a [QD];

  assign busy    = 1'b0;
  assign acc     = start && !busy;
  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign new_trk = (int'(in_track) > TRACK_COUNT - 1) ? TRK_MAX : in_track;

  assign cmd.add   = acc && (in_func == FN_ADD) && !full;
  assign cmd.srv   = acc && (in_func == FN_SERVE) && !empty;
  assign cmd.sweep = !(|ge_a);

  for (genvar i = 0; i < QD; i++) begin : g_cell
    logic              l_valid, l_ins, l_rm, r_valid;
    logic [TRK_W-1:0]  l_trk, r_trk;
    logic [TYPE_W-1:0] l_typ, r_typ;
    logic [PID_W-1:0]  l_pid, r_pid;

    if (i == 0) begin : g_first
      assign l_valid = 1'b0;
      assign l_trk   = '0;
      assign l_typ   = '0;
      assign l_pid   = '0;
      assign l_ins   = 1'b0;
      assign l_rm    = 1'b0;
    end else begin : g_mid
      assign l_valid = vld_a[i-1];
      assign l_trk   = trk_a[i-1];
      assign l_typ   = typ_a[i-1];
      assign l_pid   = pid_a[i-1];
      assign l_ins   = ins_a[i-1];
      assign l_rm    = rm_a[i-1];
    end

    if (i == QD - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_trk   = '0;
      assign r_typ   = '0;
      assign r_pid   = '0;
    end else begin : g_inner
      assign r_valid = vld_a[i+1];
      assign r_trk   = trk_a[i+1];
      assign r_typ   = typ_a[i+1];
      assign r_pid   = pid_a[i+1];
    end

    sdrs_cell #(
      .TRK_W (TRK_W),
      .PID_W (PID_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .new_trk   (new_trk),
      .new_typ   (in_op_type),
      .new_pid   (in_process_id),
      .head      (head_r),
      .lft_valid (l_valid),
      .lft_trk   (l_trk),
      .lft_typ   (l_typ),
      .lft_pid   (l_pid),
      .lft_ins   (l_ins),
      .lft_rm    (l_rm),
      .rgt_valid (r_valid),
      .rgt_trk   (r_trk),
      .rgt_typ   (r_typ),
      .rgt_pid   (r_pid),
      .valid     (vld_a[i]),
      .trk       (trk_a[i]),
      .typ       (typ_a[i]),
      .pid       (pid_a[i]),
      .ins       (ins_a[i]),
      .rm        (rm_a[i]),
      .ge        (ge_a[i]),
      .hit       (hit_a[i])
    );
  end

  // served entry
  logic [TRK_W-1:0]  sel_trk, dist_trk;
  logic [TYPE_W-1:0] sel_typ;
  logic [PID_W-1:0]  sel_pid;

  always_comb begin
    sel_trk = '0;
    sel_typ = '0;
    sel_pid = '0;
    for (int i = 0; i < QD; i++) begin
      sel_trk = sel_trk | (hit_a[i] ? trk_a[i] : '0);
      sel_typ = sel_typ | (hit_a[i] ? typ_a[i] : '0);
      sel_pid = sel_pid | (hit_a[i] ? pid_a[i] : '0);
    end
  end

  assign dist_trk = sel_trk - (cmd.sweep ? '0 : head_r);
  assign head_nxt = cmd.srv ? sel_trk : head_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.add) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.srv) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // stage 1: beat decoded
  logic                s1_vld_r;
  logic [STATUS_W-1:0] s1_status_r, s1_status_nxt;
  logic [TRK_W-1:0]    s1_trk_r, s1_dist_r;
  logic [TYPE_W-1:0]   s1_typ_r;
  logic [PID_W-1:0]    s1_pid_r;
  logic                s1_sweep_r;
  logic [PEND_W-1:0]   s1_pend_r, pend_sat;

  always_comb begin
    if (in_func == FN_ADD) begin
      s1_status_nxt = full ? ST_FULL : ST_ADDED;
    end else begin
      s1_status_nxt = empty ? ST_EMPTY : ST_SERVED;
    end
  end

  assign pend_sat = (int'(cnt_nxt) > PEND_MAX) ? PEND_W'(PEND_MAX) : PEND_W'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_status_r <= s1_status_nxt;
    s1_pend_r   <= pend_sat;
    s1_trk_r    <= cmd.srv ? sel_trk : '0;
    s1_typ_r    <= cmd.srv ? sel_typ : '0;
    s1_pid_r    <= cmd.srv ? sel_pid : '0;
    s1_dist_r   <= cmd.srv ? dist_trk : '0;
    s1_sweep_r  <= cmd.srv && cmd.sweep;
  end

  // stage 2: service time
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  sum;
  logic [TIME_W-1:0] time_sat;
  logic              out_valid_r;

  assign prod     = PROD_W'(s1_dist_r) * PROD_W'(move_r);
  assign sum      = SUM_W'(prod) + SUM_W'(op_r);
  assign time_sat = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_status         <= s1_status_r;
    out_served_track   <= s1_trk_r;
    out_served_type    <= s1_typ_r;
    out_served_process <= s1_pid_r;
    out_service_time   <= (s1_status_r == ST_SERVED) ? time_sat : '0;
    out_new_sweep      <= s1_sweep_r;
    out_pending        <= s1_pend_r;
  end

  assign out_valid = out_valid_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("pending count beyond queue depth");

  a_cnt_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_a) == int'(cnt_r))
    else $error("valid cells disagree with pending count");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> ##1 out_valid)
    else $error("result beat missing two cycles after start");

  a_sweep_served: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_new_sweep) |-> (out_status == ST_SERVED))
    else $error("new sweep flagged without a served request");

endmodule

`default_nettype wire

FILE: src/sdrs_cell.sv
// ----------------------------------------------------------------------------
// sdrs_cell
// one slot of the sorted request row; shifts right on insert, left on removal
// ----------------------------------------------------------------------------
`default_nettype none

module sdrs_cell #(
  parameter int TRK_W = 10,
  parameter int PID_W = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire sdrs_pkg::sdrs_cmd_t       cmd,
  input  wire logic [TRK_W-1:0]          new_trk,
  input  wire logic [sdrs_pkg::TYPE_W-1:0] new_typ,
  input  wire logic [PID_W-1:0]          new_pid,
  input  wire logic [TRK_W-1:0]          head,
  input  wire logic                      lft_valid,
  input  wire logic [TRK_W-1:0]          lft_trk,
  input  wire logic [sdrs_pkg::TYPE_W-1:0] lft_typ,
  input  wire logic [PID_W-1:0]          lft_pid,
  input  wire logic                      lft_ins,
  input  wire logic                      lft_rm,
  input  wire logic                      rgt_valid,
  input  wire logic [TRK_W-1:0]          rgt_trk,
  input  wire logic [sdrs_pkg::TYPE_W-1:0] rgt_typ,
  input  wire logic [PID_W-1:0]          rgt_pid,
  output logic                           valid,
  output logic [TRK_W-1:0]               trk,
  output logic [sdrs_pkg::TYPE_W-1:0]    typ,
  output logic [PID_W-1:0]               pid,
  output logic                           ins,
  output logic                           rm,
  output logic                           ge,
  output logic                           hit
);

  import sdrs_pkg::*;

  logic              valid_r, valid_nxt;
  logic [TRK_W-1:0]  trk_r, trk_nxt;
  logic [TYPE_W-1:0] typ_r, typ_nxt;
  logic [PID_W-1:0]  pid_r, pid_nxt;

  // new request lands at or before this slot
  assign ins = !valid_r || (trk_r > new_trk);
  assign ge  = valid_r && (trk_r >= head);
  // slot at or after the one being served
  assign rm  = cmd.sweep || !valid_r || ge;
  assign hit = rm && !lft_rm;

  always_comb begin
    valid_nxt = valid_r;
    trk_nxt   = trk_r;
    typ_nxt   = typ_r;
    pid_nxt   = pid_r;
    if (cmd.add && ins) begin
      if (lft_ins) begin
        valid_nxt = lft_valid;
        trk_nxt   = lft_trk;
        typ_nxt   = lft_typ;
        pid_nxt   = lft_pid;
      end else begin
        valid_nxt = 1'b1;
        trk_nxt   = new_trk;
        typ_nxt   = new_typ;
        pid_nxt   = new_pid;
      end
    end else if (cmd.srv && rm) begin
      valid_nxt = rgt_valid;
      trk_nxt   = rgt_trk;
      typ_nxt   = rgt_typ;
      pid_nxt   = rgt_pid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    trk_r <= trk_nxt;
    typ_r <= typ_nxt;
    pid_r <= pid_nxt;
  end

  assign valid = valid_r;
  assign trk   = trk_r;
  assign typ   = typ_r;
  assign pid   = pid_r;

endmodule

`default_nettype wire

FILE: verif/tb_sweep_disk_request_scheduler.sv
// ----------------------------------------------------------------------------
// tb_sweep_disk_request_scheduler
// self-checking bench for the circular-scan disk request queue: a queue-based
// model of the sorted request list and the head position predicts each result
// beat; directed items cover empty and full queues, equal tracks, track
// extremes and the wrap to a new sweep, then random add/serve traffic runs
// under several per-track and operation cost settings written over APB
// ----------------------------------------------------------------------------
module tb_sweep_disk_request_scheduler;
  import sdrs_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int TRACKS      = 1024;
  localparam int PID_W       = 8;
  localparam int TRK_W       = $clog2(TRACKS);
  localparam int TRACK_MAX   = TRACKS - 1;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [TRK_W-1:0]  trk;
    logic [TYPE_W-1:0] kind;
    logic [PID_W-1:0]  pid;
  } disk_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [TRK_W-1:0]    trk;
    logic [TYPE_W-1:0]   kind;
    logic [PID_W-1:0]    pid;
    logic [TIME_W-1:0]   cost;
    logic                sweep;
    logic [PEND_W-1:0]   pend;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_func = FN_ADD;
  logic [TRK_W-1:0] in_track = '0;
  logic [TYPE_W-1:0] in_op_type = '0;
  logic [PID_W-1:0] in_process_id = '0;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [TRK_W-1:0] out_served_track;
  logic [TYPE_W-1:0] out_served_type;
  logic [PID_W-1:0] out_served_process;
  logic [TIME_W-1:0] out_service_time;
  logic out_new_sweep;
  logic [PEND_W-1:0] out_pending;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  always #5 clk = ~clk;

  sweep_disk_request_scheduler #(
    .QUEUE_DEPTH(QDEPTH),
    .TRACK_COUNT(TRACKS),
    .PROCESS_ID_BITS(PID_W)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_track(in_track),
    .in_op_type(in_op_type),
    .in_process_id(in_process_id),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_served_track(out_served_track),
    .out_served_type(out_served_type),
    .out_served_process(out_served_process),
    .out_service_time(out_service_time),
    .out_new_sweep(out_new_sweep),
    .out_pending(out_pending),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  disk_req_t pending_reqs[$];
  logic [TRK_W-1:0] head_trk = '0;
  logic [CFG_REG_W-1:0] move_cost = MOVE_RST;
  logic [CFG_REG_W-1:0] op_cost = OP_RST;
  sched_result_t due_results[$];
  int error_count = 0;
  int stall_cycles = 0;
  bit idle_en = 1'b1;

  function automatic sched_result_t schedule_item(logic fn, logic [TRK_W-1:0] trk,
                                                  logic [TYPE_W-1:0] kind,
                                                  logic [PID_W-1:0] pid);
    sched_result_t res;
    disk_req_t req;
    int pos;
    int sel;
    longint cost;
    res = '{default: '0};
    if (fn == FN_ADD) begin
      if (pending_reqs.size() >= QDEPTH) begin
        res.status = ST_FULL;
        res.pend = PEND_W'(pending_reqs.size());
        return res;
      end
      pos = pending_reqs.size();
      for (int i = 0; i < pending_reqs.size(); i++) begin
        if (pending_reqs[i].trk > trk) begin
          pos = i;
          break;
        end
      end
      req.trk = trk;
      req.kind = kind;
      req.pid = pid;
      pending_reqs.insert(pos, req);
      res.status = ST_ADDED;
    end else if (pending_reqs.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      sel = -1;
      for (int i = 0; i < pending_reqs.size(); i++) begin
        if (pending_reqs[i].trk >= head_trk) begin
          sel = i;
          break;
        end
      end
      if (sel < 0) begin
        res.sweep = 1'b1;
        head_trk = '0;
        sel = 0;
      end
      req = pending_reqs[sel];
      cost = (longint'(req.trk) - longint'(head_trk)) * longint'(move_cost)
             + longint'(op_cost);
      if (cost > TIME_MAX) cost = TIME_MAX;
      head_trk = req.trk;
      res.status = ST_SERVED;
      res.trk = req.trk;
      res.kind = req.kind;
      res.pid = req.pid;
      res.cost = TIME_W'(cost);
      pending_reqs.delete(sel);
    end
    res.pend = PEND_W'(pending_reqs.size());
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // result beats are checked in order against the oldest prediction
  always @(posedge clk) begin
    sched_result_t exp_res;
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        $error("unexpected result beat, status %0d", out_status);
        error_count++;
      end else begin
        exp_res = due_results.pop_front();
        check_field("status", exp_res.status, out_status);
        check_field("served_track", exp_res.trk, out_served_track);
        check_field("served_type", exp_res.kind, out_served_type);
        check_field("served_process", exp_res.pid, out_served_process);
        check_field("service_time", exp_res.cost, out_service_time);
        check_field("new_sweep", exp_res.sweep, out_new_sweep);
        check_field("pending", exp_res.pend, out_pending);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(logic fn, logic [TRK_W-1:0] trk, logic [TYPE_W-1:0] kind,
                           logic [PID_W-1:0] pid);
    while (idle_en && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_func <= fn;
    in_track <= trk;
    in_op_type <= kind;
    in_process_id <= pid;
    do @(posedge clk); while (busy);
    due_results.push_back(schedule_item(fn, trk, kind, pid));
  endtask

  task automatic settle();
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_REG_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {(CFG_DATA_W-CFG_REG_W)'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == CFG_IDX_MOVE) move_cost = val;
    else op_cost = val;
  endtask

  task automatic set_costs(logic [CFG_REG_W-1:0] move_val, logic [CFG_REG_W-1:0] op_val);
    settle();
    write_reg(CFG_IDX_MOVE, move_val);
    write_reg(CFG_IDX_OP, op_val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_items(int count);
    int add_pct;
    int pick;
    logic fn;
    logic [TRK_W-1:0] trk;
    add_pct = 50;
    for (int n = 0; n < count; n++) begin
      // swing between filling and draining so both full and empty get hit
      if (n % 40 == 0) add_pct = 20 + 30 * $urandom_range(2);
      fn = ($urandom_range(99) < add_pct) ? FN_ADD : FN_SERVE;
      pick = $urandom_range(9);
      if (pick == 6) trk = head_trk;
      else if (pick == 7)
        trk = (head_trk > TRACK_MAX - 3) ? TRK_W'(TRACK_MAX)
                                         : TRK_W'(head_trk + $urandom_range(3));
      else if (pick == 8)
        trk = (head_trk < 3) ? '0 : TRK_W'(head_trk - $urandom_range(3));
      else if (pick == 9 && pending_reqs.size() != 0)
        trk = pending_reqs[$urandom_range(pending_reqs.size() - 1)].trk;
      else if (pick == 9)
        trk = $urandom_range(1) ? TRK_W'(TRACK_MAX) : '0;
      else trk = TRK_W'($urandom);
      send_item(fn, trk, TYPE_W'($urandom), PID_W'($urandom));
    end
  endtask

  task automatic test_directed_basics();
    send_item(FN_SERVE, '0, '0, '0);
    send_item(FN_ADD, '0, '0, '0);
    send_item(FN_ADD, TRK_W'(TRACK_MAX), '1, '1);
    // equal track goes behind the earlier one
    send_item(FN_ADD, '0, '1, '1);
    send_item(FN_SERVE, '0, '0, '0);
    send_item(FN_SERVE, '0, '0, '0);
    send_item(FN_SERVE, '0, '0, '0);
    // nothing at or above the head, so the head wraps
    send_item(FN_ADD, TRK_W'(512), TYPE_W'(5), PID_W'(8'ha5));
    send_item(FN_SERVE, '1, '1, '1);
    // request landing on the head is served in this sweep
    send_item(FN_ADD, TRK_W'(512), TYPE_W'(10), PID_W'(8'h5a));
    send_item(FN_SERVE, '0, '0, '0);
  endtask

  task automatic test_queue_full();
    for (int n = 0; n <= QDEPTH; n++)
      send_item(FN_ADD, (n % 5 == 0) ? TRK_W'(300) : TRK_W'($urandom),
                TYPE_W'($urandom), PID_W'($urandom));
  endtask

  task automatic test_cost_settings();
    logic [CFG_REG_W-1:0] move_vals[6];
    logic [CFG_REG_W-1:0] op_vals[6];
    move_vals = '{16'd0, 16'hffff, 16'd1, 16'hffff, 16'($urandom), 16'($urandom)};
    op_vals = '{16'd0, 16'hffff, 16'hffff, 16'd0, 16'($urandom), 16'($urandom)};
    for (int p = 0; p < 6; p++) begin
      set_costs(move_vals[p], op_vals[p]);
      idle_en = (p != 3);
      random_items(325);
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_basics();
    test_queue_full();
    test_cost_settings();
    settle();
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
